>>> hw/rtl/metasprite_oam_builder_top_macros.svh
// Assertion macros shared by the metasprite OAM builder RTL.
`ifndef METASPRITE_OAM_BUILDER_TOP_MACROS_SVH
`define METASPRITE_OAM_BUILDER_TOP_MACROS_SVH

`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define MOB_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("mob assertion failed");
// Check that an antecedent implies a consequent in the next clock cycle.
`define MOB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mob assertion failed");
`else
`define MOB_ASSERT(lbl, cond)
`define MOB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/mob_pkg.sv
// Package: types, constants and helpers of the metasprite OAM builder.
package mob_pkg;

	// Default sprite count of the OAM
	localparam int MAX_SPRITES_DEF = 128;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_SMALL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_LARGE = 1'd1;

	// Request codes
	localparam logic REQ_ENTRY    = 1'b0;
	localparam logic REQ_SET_SLOT = 1'b1;

	// Cull window on screen X: 0x100..0x1BF
	localparam logic [8:0] CULL_LOW  = 9'h100;
	localparam logic [8:0] CULL_HIGH = 9'h1C0;

	// Attribute word bits
	localparam logic [15:0] ATTR_HFLIP   = 16'h4000;
	localparam logic [15:0] ATTR_VFLIP   = 16'h8000;
	localparam logic [15:0] ATTR_PALETTE = 16'h3000;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  start_slot;
		logic        full_mode;
		logic        h_flip;
		logic        v_flip;
		logic [1:0]  palette_bits;
		logic [8:0]  base_x;
		logic [7:0]  base_y;
		logic [9:0]  x_offset;
		logic [7:0]  y_offset;
		logic [15:0] tile_word;
	} entry_t;

	typedef struct packed {
		logic [6:0]  sprite_number;
		logic [7:0]  pos_x_low;
		logic [7:0]  pos_y;
		logic [7:0]  tile_number;
		logic [7:0]  attribute_byte;
		logic [3:0]  upper_word_index;
		logic [15:0] upper_word;
	} result_t;

	// Classified word handed from front to back
	typedef struct packed {
		logic        req_type;
		logic [7:0]  slot;       // saturated new slot for a set-slot request
		logic        size_big;
		logic [8:0]  spr_x;
		logic [7:0]  spr_y;
		logic [15:0] tile_word;
	} cmd_t;

	// Spread a two-bit pair over all eight sprite positions of a word
	function automatic logic [15:0] replicate2(input logic [1:0] two_bits);
		logic [15:0] pat;
		case (two_bits)
			2'd0:    pat = 16'h0000;
			2'd1:    pat = 16'h5555;
			2'd2:    pat = 16'hAAAA;
			default: pat = 16'hFFFF;
		endcase
		return pat;
	endfunction

endpackage

>>> hw/rtl/mob_stream_if.sv
// Valid/ready stream interface carrying one word of a given payload type.
interface mob_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/mob_front.sv
// Front: holds the mirror registers, computes screen position, culls, builds attributes.
module mob_front
	import mob_pkg::*;
#(
	parameter int MAX_SPRITES = MAX_SPRITES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	mob_stream_if.sink            entry,
	mob_stream_if.source          cmd
);

	logic [15:0] mirror_small_q;
	logic [15:0] mirror_large_q;

	entry_t      e;
	logic        size_big;
	logic [15:0] mir;
	logic [8:0]  off_x;
	logic [8:0]  sx;
	logic [7:0]  sy;
	logic        culled;
	logic [15:0] ta;
	logic [7:0]  slot_sat;
	cmd_t        c;

	// Write mirror registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_small_q <= '0;
			mirror_large_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MIRROR_SMALL: mirror_small_q <= cfg_wdata;
				CFG_MIRROR_LARGE: mirror_large_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Compute screen position and attribute word
	always_comb begin
		e        = entry.data;
		size_big = e.x_offset[9];
		mir      = size_big ? mirror_large_q : mirror_small_q;
		off_x    = e.x_offset[8:0];

		if (e.full_mode && e.h_flip)
			sx = e.base_x - off_x - mir[8:0];
		else
			sx = e.base_x + off_x;

		if (e.full_mode && e.v_flip)
			sy = e.base_y - e.y_offset - mir[7:0];
		else
			sy = e.base_y + e.y_offset;

		ta = e.tile_word;
		if (e.full_mode) begin
			if (e.h_flip)
				ta = ta ^ ATTR_HFLIP;
			if (e.v_flip)
				ta = ta ^ ATTR_VFLIP;
			ta = ta | ({2'b00, e.palette_bits, 12'h000} & ATTR_PALETTE);
		end

		culled = (e.req_type == REQ_ENTRY) && e.full_mode
			&& (sx >= CULL_LOW) && (sx < CULL_HIGH);

		// Saturate the new slot at the sprite count
		if ({1'b0, e.start_slot} > 9'(MAX_SPRITES))
			slot_sat = 8'(MAX_SPRITES);
		else
			slot_sat = e.start_slot;

		c.req_type  = e.req_type;
		c.slot      = slot_sat;
		c.size_big  = size_big;
		c.spr_x     = sx;
		c.spr_y     = sy;
		c.tile_word = ta;
	end

	// Drop culled entries here; pass everything else to the queue
	assign cmd.valid   = entry.valid && !culled;
	assign cmd.data    = c;
	assign entry.ready = cmd.ready;

endmodule

>>> hw/rtl/mob_queue.sv
// Short queue of classified words between front and back.
module mob_queue
	import mob_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mob_stream_if.sink   wr,
	mob_stream_if.source rd
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign wr.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.data  = mem_q[rptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	// Store pushed word
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wr.data;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/mob_back.sv
// Back: write slot, upper attribute table and the result register.
module mob_back
	import mob_pkg::*;
#(
	parameter int MAX_SPRITES = MAX_SPRITES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mob_stream_if.sink   cmd,
	mob_stream_if.source result
);

	localparam int SLOT_W  = $clog2(MAX_SPRITES + 1);
	localparam int IDX_W   = $clog2(MAX_SPRITES);
	localparam int WIDX_W  = (IDX_W > 3) ? IDX_W - 3 : 1;
	localparam int WORDS   = 1 << WIDX_W;

	logic [SLOT_W-1:0] write_slot_q;
	logic [15:0]       upper_q [WORDS];
	logic              out_valid_q;
	result_t           out_data_q;

	cmd_t              c;
	logic              take;
	logic              fire;
	logic              emit;
	logic [6:0]        slot7;
	logic [3:0]        widx4;
	logic [WIDX_W-1:0] widx;
	logic [2:0]        sub;
	logic [15:0]       mask;
	logic [15:0]       new_word;

	assign c    = cmd.data;
	assign take = !out_valid_q || result.ready;
	assign fire = cmd.valid && take;
	assign emit = fire && (c.req_type == REQ_ENTRY)
		&& (write_slot_q < SLOT_W'(MAX_SPRITES));

	// Locate the sprite's pair in the upper table and merge the new bits
	always_comb begin
		slot7    = 7'(write_slot_q);
		widx4    = 4'(slot7 >> 3);
		widx     = widx4[WIDX_W-1:0];
		sub      = slot7[2:0];
		mask     = 16'h0003 << {sub, 1'b0};
		new_word = (upper_q[widx] & ~mask)
			| (replicate2({c.size_big, c.spr_x[8]}) & mask);
	end

	// Update slot and table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			for (int i = 0; i < WORDS; i++)
				upper_q[i] <= '0;
		end else if (fire) begin
			if (c.req_type == REQ_SET_SLOT) begin
				write_slot_q <= c.slot[SLOT_W-1:0];
			end else if (emit) begin
				write_slot_q  <= write_slot_q + 1'b1;
				upper_q[widx] <= new_word;
			end
		end
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.sprite_number    <= slot7;
			out_data_q.pos_x_low        <= c.spr_x[7:0];
			out_data_q.pos_y            <= c.spr_y;
			out_data_q.tile_number      <= c.tile_word[7:0];
			out_data_q.attribute_byte   <= c.tile_word[15:8];
			out_data_q.upper_word_index <= widx4;
			out_data_q.upper_word       <= new_word;
		end
	end

	assign cmd.ready    = take;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

endmodule

>>> hw/rtl/metasprite_oam_builder_top.sv
// Top level of the metasprite OAM builder: front, queue and back.
// Takes one sub-sprite entry or set-slot request per cycle while results are taken, and
// returns at most one OAM result per entry, registered first in the four-word queue and
// then in the result register; an untaken result stalls the back end and fills the queue.
// The upper table is read and rewritten in the same cycle. Culled entries are dropped in
// the front end and entries that arrive with the write slot at MAX_SPRITES in the back
// end; neither gives a result. The mirror registers are written through cfg_we/cfg_addr/
// cfg_wdata, by the user only while the block is idle; the block does not enforce this.
`include "metasprite_oam_builder_top_macros.svh"
module metasprite_oam_builder_top
	import mob_pkg::*;
#(
	parameter int MAX_SPRITES = MAX_SPRITES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	mob_stream_if.sink            entry,
	mob_stream_if.source          result
);

	mob_stream_if #(.T(cmd_t)) q_in ();
	mob_stream_if #(.T(cmd_t)) q_out ();

	mob_front #(
		.MAX_SPRITES(MAX_SPRITES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.entry     (entry),
		.cmd       (q_in)
	);

	mob_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_in),
		.rd     (q_out)
	);

	mob_back #(
		.MAX_SPRITES(MAX_SPRITES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (q_out),
		.result (result)
	);

	// A pushed word leaves the queue non-empty
	`MOB_ASSERT_NEXT(a_push_fills, q_in.valid && q_in.ready, q_out.valid)
	// A taken result with nothing popped leaves the output empty
	`MOB_ASSERT_NEXT(a_out_drains, result.valid && result.ready && !q_out.valid, !result.valid)
	// Upper word index follows from the sprite number
	`MOB_ASSERT(a_widx, !result.valid || (result.data.upper_word_index == 4'(result.data.sprite_number >> 3)))

endmodule

>>> bench/metasprite_oam_builder_top_tb.sv
// Testbench for the metasprite OAM builder: directed and random entries against a predictor.
`timescale 1ns / 1ps
module metasprite_oam_builder_top_tb;
	import mob_pkg::*;

	localparam int SPRITE_SLOTS = MAX_SPRITES_DEF;
	localparam int RANDOM_ITEMS = 1280;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mob_stream_if #(.T(entry_t))  entry_if ();
	mob_stream_if #(.T(result_t)) result_if ();

	metasprite_oam_builder_top #(
		.MAX_SPRITES(SPRITE_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.entry(entry_if),
		.result(result_if)
	);

	// Predictor state
	logic [15:0] mirror_small_q;
	logic [15:0] mirror_large_q;
	logic [7:0]  next_slot;
	logic [15:0] upper_attr [16];

	result_t oam_expect_q [$];
	int      fail_count;
	int      cycle_count;
	bit      idle_on;
	int      hold_request;
	int      hold_left;
	int      stall_left;

	// Clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Compute the OAM word an entry produces; return 0 when it produces none
	function automatic bit predict_oam(input entry_t w, output result_t r);
		logic [8:0]  sx;
		logic [7:0]  sy;
		logic        size_big;
		logic [15:0] mir;
		logic [15:0] ta;
		logic [15:0] cur;
		logic [15:0] mask;
		logic [6:0]  slot;
		logic [3:0]  widx;
		logic [2:0]  sub;
		logic [1:0]  hi;
		logic [8:0]  off_x;
		r = '0;
		if (w.req_type == REQ_SET_SLOT) begin
			next_slot = (w.start_slot > SPRITE_SLOTS) ? 8'(SPRITE_SLOTS) : w.start_slot;
			return 1'b0;
		end
		// drop entries once every slot is used
		if (next_slot >= SPRITE_SLOTS)
			return 1'b0;
		size_big = w.x_offset[9];
		mir      = size_big ? mirror_large_q : mirror_small_q;
		off_x    = w.x_offset[8:0];
		if (w.full_mode && w.h_flip)
			sx = 9'(w.base_x - off_x - mir);
		else
			sx = w.base_x + off_x;
		if (w.full_mode && w.v_flip)
			sy = 8'(w.base_y - w.y_offset - mir);
		else
			sy = w.base_y + w.y_offset;
		ta = w.tile_word;
		if (w.full_mode) begin
			// cull the hidden X band before touching any state
			if (sx >= CULL_LOW && sx < CULL_HIGH)
				return 1'b0;
			if (w.h_flip)
				ta = ta ^ ATTR_HFLIP;
			if (w.v_flip)
				ta = ta ^ ATTR_VFLIP;
			ta = ta | (({14'd0, w.palette_bits} << 12) & ATTR_PALETTE);
		end
		slot = next_slot[6:0];
		widx = slot[6:3];
		sub  = slot[2:0];
		hi   = {size_big, sx[8]};
		mask = 16'd3 << (2 * sub);
		cur  = (upper_attr[widx] & ~mask) | ({8{hi}} & mask);
		upper_attr[widx] = cur;
		next_slot = next_slot + 8'd1;
		r.sprite_number    = slot;
		r.pos_x_low        = sx[7:0];
		r.pos_y            = sy;
		r.tile_number      = ta[7:0];
		r.attribute_byte   = ta[15:8];
		r.upper_word_index = widx;
		r.upper_word       = cur;
		return 1'b1;
	endfunction

	// Queue the expected word of each accepted entry
	always @(posedge clk) begin : predict_words
		result_t r;
		if (arst_n && entry_if.valid && entry_if.ready) begin
			if (predict_oam(entry_if.data, r))
				oam_expect_q.push_back(r);
		end
	end

	task automatic report_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Compare each delivered word with the oldest expectation
	always @(posedge clk) begin : check_words
		result_t want;
		result_t got;
		if (arst_n && result_if.valid && result_if.ready) begin
			got = result_if.data;
			if (oam_expect_q.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual %p", $time, got);
				fail_count++;
			end else begin
				want = oam_expect_q.pop_front();
				report_field("sprite_number", 16'(want.sprite_number),
					16'(got.sprite_number));
				report_field("pos_x_low", 16'(want.pos_x_low), 16'(got.pos_x_low));
				report_field("pos_y", 16'(want.pos_y), 16'(got.pos_y));
				report_field("tile_number", 16'(want.tile_number), 16'(got.tile_number));
				report_field("attribute_byte", 16'(want.attribute_byte),
					16'(got.attribute_byte));
				report_field("upper_word_index", 16'(want.upper_word_index),
					16'(got.upper_word_index));
				report_field("upper_word", want.upper_word, got.upper_word);
			end
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int gap_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// Drive result ready: long hold on request, otherwise random stalls
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			result_if.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			result_if.ready <= 1'b0;
			stall_left--;
		end else begin
			result_if.ready <= 1'b1;
			if (idle_on && $urandom_range(0, 3) == 0)
				stall_left = gap_len();
		end
	end

	// Offer one word and hold it until accepted; enter and leave at a falling edge
	task automatic send_word(input entry_t w);
		int g;
		g = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (g > 0) begin
			entry_if.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		entry_if.valid <= 1'b1;
		entry_if.data  <= w;
		do
			@(posedge clk);
		while (!entry_if.ready);
		@(negedge clk);
	endtask

	// Stop offering, wait for every expected word, then let the pipeline settle
	task automatic wait_idle();
		entry_if.valid <= 1'b0;
		while (oam_expect_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write both mirror registers while the block is idle
	task automatic load_mirrors(input logic [15:0] small_val, input logic [15:0] large_val);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_MIRROR_SMALL;
		cfg_wdata <= small_val;
		@(negedge clk);
		cfg_addr  <= CFG_MIRROR_LARGE;
		cfg_wdata <= large_val;
		@(negedge clk);
		cfg_we <= 1'b0;
		mirror_small_q = small_val;
		mirror_large_q = large_val;
	endtask

	function automatic entry_t rand_entry();
		entry_t w;
		w.req_type     = 1'($urandom_range(0, 1));
		w.start_slot   = 8'($urandom_range(0, 255));
		w.full_mode    = 1'($urandom_range(0, 1));
		w.h_flip       = 1'($urandom_range(0, 1));
		w.v_flip       = 1'($urandom_range(0, 1));
		w.palette_bits = 2'($urandom_range(0, 3));
		w.base_x       = 9'($urandom_range(0, 511));
		w.base_y       = 8'($urandom_range(0, 255));
		w.x_offset     = 10'($urandom_range(0, 1023));
		w.y_offset     = 8'($urandom_range(0, 255));
		w.tile_word    = 16'($urandom_range(0, 65535));
		return w;
	endfunction

	function automatic entry_t mk_entry(input logic full, input logic hf, input logic vf,
			input logic [1:0] pal, input logic [8:0] bx, input logic [7:0] by,
			input logic [9:0] xo, input logic [7:0] yo, input logic [15:0] ta);
		entry_t w;
		w = rand_entry();
		w.req_type     = REQ_ENTRY;
		w.full_mode    = full;
		w.h_flip       = hf;
		w.v_flip       = vf;
		w.palette_bits = pal;
		w.base_x       = bx;
		w.base_y       = by;
		w.x_offset     = xo;
		w.y_offset     = yo;
		w.tile_word    = ta;
		return w;
	endfunction

	function automatic entry_t mk_set_slot(input logic [7:0] s);
		entry_t w;
		w = rand_entry();
		w.req_type   = REQ_SET_SLOT;
		w.start_slot = s;
		return w;
	endfunction

	// Simple mode: plain add with wraparound, flip and palette ignored
	task automatic test_simple_mode();
		send_word(mk_entry(1'b0, 1'b0, 1'b0, 2'd0, 9'h000, 8'h00, 10'h000, 8'h00, 16'h0000));
		send_word(mk_entry(1'b0, 1'b1, 1'b1, 2'd3, 9'h1FF, 8'hFF, 10'h3FF, 8'hFF, 16'hFFFF));
		send_word(mk_entry(1'b0, 1'b0, 1'b0, 2'd0, 9'h100, 8'h10, 10'h000, 8'h01, 16'h1234));
		send_word(mk_entry(1'b0, 1'b1, 1'b0, 2'd2, 9'h080, 8'h80, 10'h080, 8'h80, 16'hA55A));
		send_word(mk_entry(1'b0, 1'b0, 1'b1, 2'd1, 9'h0F0, 8'h01, 10'h20F, 8'hFE, 16'h00FF));
		wait_idle();
	endtask

	// Full mode: mirroring, attribute flips, palette and the cull band edges
	task automatic test_full_mode();
		load_mirrors(16'd8, 16'd16);
		send_word(mk_entry(1'b1, 1'b0, 1'b0, 2'd3, 9'h0F0, 8'h20, 10'h00F, 8'h01, 16'h0000));
		send_word(mk_entry(1'b1, 1'b0, 1'b0, 2'd0, 9'h0F0, 8'h20, 10'h010, 8'h01, 16'h1111));
		send_word(mk_entry(1'b1, 1'b0, 1'b0, 2'd0, 9'h1B0, 8'h20, 10'h00F, 8'h01, 16'h2222));
		send_word(mk_entry(1'b1, 1'b0, 1'b0, 2'd1, 9'h1B0, 8'h20, 10'h010, 8'h01, 16'h3333));
		send_word(mk_entry(1'b1, 1'b1, 1'b0, 2'd0, 9'h020, 8'h40, 10'h004, 8'h02, 16'hFFFF));
		send_word(mk_entry(1'b1, 1'b0, 1'b1, 2'd2, 9'h050, 8'h10, 10'h205, 8'h20, 16'h4C21));
		send_word(mk_entry(1'b1, 1'b1, 1'b1, 2'd2, 9'h000, 8'h00, 10'h001, 8'h01, 16'h0000));
		send_word(mk_entry(1'b1, 1'b1, 1'b0, 2'd3, 9'h190, 8'h30, 10'h008, 8'h00, 16'h8001));
		send_word(mk_entry(1'b1, 1'b0, 1'b0, 2'd1, 9'h1FF, 8'hFF, 10'h3FF, 8'hFF, 16'hC0DE));
		wait_idle();
	endtask

	// Slot range: saturation of the set-slot request and drops when full
	task automatic test_slot_limit();
		send_word(mk_set_slot(8'd126));
		repeat (4) send_word(mk_entry(1'b0, 1'b0, 1'b0, 2'd0, 9'($urandom_range(0, 511)),
			8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
			8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))));
		send_word(mk_set_slot(8'd200));
		send_word(mk_entry(1'b0, 1'b0, 1'b0, 2'd0, 9'h010, 8'h10, 10'h010, 8'h10, 16'h5A5A));
		send_word(mk_set_slot(8'd128));
		send_word(mk_entry(1'b1, 1'b0, 1'b0, 2'd0, 9'h010, 8'h10, 10'h010, 8'h10, 16'h5A5A));
		send_word(mk_set_slot(8'd127));
		send_word(mk_entry(1'b0, 1'b0, 1'b0, 2'd0, 9'h1FF, 8'h00, 10'h201, 8'h00, 16'hFFFF));
		wait_idle();
	endtask

	// Random metasprites: a set-slot then a run of entries sharing one object, plus noise
	task automatic test_random_phases();
		int     sent;
		int     phase;
		int     in_phase;
		int     n;
		entry_t obj;
		entry_t w;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase % 4)
				0: load_mirrors(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
				1: load_mirrors(16'h0000, 16'hFFFF);
				2: load_mirrors(16'hFFFF, 16'h0000);
				default: load_mirrors(16'($urandom_range(0, 31)), 16'($urandom_range(0, 31)));
			endcase
			idle_on = (phase % 3 != 2);
			// fill the block against a receiver that holds off
			if (phase == 0) begin
				idle_on      = 1'b0;
				hold_request = 80;
			end
			in_phase = 0;
			while (in_phase < 150 && sent + in_phase < RANDOM_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					send_word(rand_entry());
					in_phase++;
				end else begin
					if ($urandom_range(0, 9) == 0)
						w = mk_set_slot(8'($urandom_range(128, 255)));
					else if ($urandom_range(0, 7) == 0)
						w = mk_set_slot(8'($urandom_range(112, 127)));
					else
						w = mk_set_slot(8'($urandom_range(0, 127)));
					send_word(w);
					obj = rand_entry();
					n   = $urandom_range(1, 16);
					in_phase += n + 1;
					repeat (n) begin
						send_word(mk_entry(obj.full_mode, obj.h_flip, obj.v_flip,
							obj.palette_bits, obj.base_x, obj.base_y,
							10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
							16'($urandom_range(0, 65535))));
					end
				end
			end
			sent += in_phase;
			wait_idle();
			phase++;
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_addr        = CFG_MIRROR_SMALL;
		cfg_wdata       = '0;
		entry_if.valid  = 1'b0;
		entry_if.data   = '0;
		result_if.ready = 1'b0;
		mirror_small_q  = '0;
		mirror_large_q  = '0;
		next_slot       = '0;
		for (int i = 0; i < 16; i++)
			upper_attr[i] = '0;
		fail_count   = 0;
		cycle_count  = 0;
		idle_on      = 1'b1;
		hold_request = 0;
		hold_left    = 0;
		stall_left   = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_simple_mode();
		test_full_mode();
		test_slot_limit();
		test_random_phases();
		wait_idle();

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
